/* rtl/core/keyed_edge_detect_cache_macros.svh */
// Assertion macros shared by the checker of the keyed edge detect cache.
`ifndef KEYED_EDGE_DETECT_CACHE_MACROS_SVH
`define KEYED_EDGE_DETECT_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define KEDC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed edge detect cache: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define KEDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed edge detect cache: assertion failed");

`endif

/* rtl/core/kedc_pkg.sv */
// Package: payload types, status codes and controller/datapath links.
`default_nettype none

package kedc_pkg;

   localparam int CACHE_SLOTS_DEF = 16;

   typedef enum logic [1:0] {
      ST_HIT       = 2'd0,
      ST_NEW       = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef struct packed {
      logic [8:0]  key_code;
      logic        key_held;
      logic [31:0] frame_number;
      logic        source_ready;
   } req_type;

   typedef struct packed {
      logic       rising_edge;
      logic [1:0] lookup_status;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  key;
      logic        prev_level;
      logic        edge_flag;
      logic [31:0] frame;
   } slot_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;
      logic       advance;
      logic       finish;
      status_type status;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic src_ready;
      logic exhausted;
      logic table_full;
      logic key_match;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/kedc_ctrl.sv */
// Controller: sequences the accept, the slot search and the result write.
`default_nettype none

module kedc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kedc_pkg::sts_type sts,
   output kedc_pkg::cmd_type      cmd
);
   import kedc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_SEARCH = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      decided;
   status_type decision;

   always_comb begin
      decided  = 1'b1;
      decision = ST_HIT;
      if (!sts.src_ready) begin
         decision = ST_NOT_READY;
      end else if (sts.exhausted) begin
         decision = sts.table_full ? ST_FULL : ST_NEW;
      end else if (sts.key_match) begin
         decision = ST_HIT;
      end else begin
         decided = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      cmd.finish  = 1'b0;
      cmd.status  = decision;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!decided) begin
               cmd.advance = 1'b1;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/kedc_datapath.sv */
// Datapath: query register, slot memory, search index, fill count, result register.
`default_nettype none

module kedc_datapath #(
   parameter int CACHE_SLOTS = kedc_pkg::CACHE_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kedc_pkg::req_type req_data,
   input  wire kedc_pkg::cmd_type cmd,
   output kedc_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kedc_pkg::rsp_type      rsp_data
);
   import kedc_pkg::*;

   localparam int ADDR_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
   localparam int IDX_W  = $clog2(CACHE_SLOTS + 1);

   req_type            query_ff, query_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   used_ff, used_in;
   slot_type           slot_mem [CACHE_SLOTS];
   slot_type           slot_rd_ff;
   slot_type           wr_slot;
   logic               wr_en;
   logic               frame_same;
   logic               edge_now;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   assign query_in = cmd.load ? req_data : query_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign frame_same = (slot_rd_ff.frame == query_ff.frame_number);
   assign edge_now   = frame_same ? slot_rd_ff.edge_flag
                                  : (query_ff.key_held & ~slot_rd_ff.prev_level);

   always_comb begin
      wr_en   = 1'b0;
      wr_slot = slot_rd_ff;
      used_in = used_ff;
      if (cmd.finish && cmd.status == ST_NEW) begin
         wr_en              = 1'b1;
         wr_slot.key        = query_ff.key_code;
         wr_slot.prev_level = query_ff.key_held;
         wr_slot.edge_flag  = 1'b0;
         wr_slot.frame      = query_ff.frame_number;
         used_in            = used_ff + IDX_W'(1);
      end else if (cmd.finish && cmd.status == ST_HIT && !frame_same) begin
         wr_en              = 1'b1;
         wr_slot.prev_level = query_ff.key_held;
         wr_slot.edge_flag  = edge_now;
         wr_slot.frame      = query_ff.frame_number;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[idx_ff[ADDR_W-1:0]] <= wr_slot;
      end
      slot_rd_ff <= slot_mem[idx_in[ADDR_W-1:0]];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.lookup_status = cmd.status;
         rsp_data_in.rising_edge   = (cmd.status == ST_HIT) ? edge_now : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff    <= query_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.src_ready  = query_ff.source_ready;
   assign sts.exhausted  = (idx_ff == used_ff);
   assign sts.table_full = (used_ff == IDX_W'(CACHE_SLOTS));
   assign sts.key_match  = (slot_rd_ff.key == query_ff.key_code);
   assign sts.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/core/keyed_edge_detect_cache.sv */
// Top level: keyed rising-edge detector with a never-evicting slot cache.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  kedc_pkg::req_type (key, level, frame, ready)
//   rsp_      out        rsp_valid / rsp_stall  kedc_pkg::rsp_type (edge, status)
//
// One query at a time. A transfer on req_ loads the query register, then the search compares one
// slot per cycle against the registered read port of the slot memory, stopping at slot k for
// a hit in slot k and once all slots_used slots are passed for a miss.
// A source-not-ready query decides in its first search cycle.
// Reset clears the fill count, the controller and the result valid; slots need no clear
// since only the first slots_used entries are ever compared.
// A stalled result holds in the output register; a query finishing meanwhile waits in the search state.
`default_nettype none

module keyed_edge_detect_cache #(
   parameter int CACHE_SLOTS = kedc_pkg::CACHE_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kedc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kedc_pkg::rsp_type      rsp_data
);
   import kedc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence accept, search steps and the final write/result.
   kedc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the query, walk the slots, update the hit or allocated slot, drive the result.
   kedc_datapath #(
      .CACHE_SLOTS (CACHE_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/kedc_checker.sv */
// Checker on the top-level ports of the keyed edge detect cache, with its bind.
`default_nettype none
`include "keyed_edge_detect_cache_macros.svh"

module kedc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire kedc_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire kedc_pkg::rsp_type rsp_data
);
   import kedc_pkg::*;

   logic req_xfer;
   logic edge_not_hit;

   assign req_xfer     = req_valid && !req_stall;
   assign edge_not_hit = rsp_data.rising_edge && (rsp_data.lookup_status != ST_HIT);

   // Busy right after taking a query.
   `KEDC_ASSERT_NEXT(busy_after_accept, req_xfer, req_stall)
   // A stalled query holds.
   `KEDC_ASSERT_NEXT(req_hold, req_valid && req_stall, req_valid && $stable(req_data))
   // Only a hit may report an edge.
   `KEDC_ASSERT_SAME(edge_only_on_hit, rsp_valid, !edge_not_hit)
   // A new result follows a busy cycle.
   `KEDC_ASSERT_SAME(result_after_search, $rose(rsp_valid), $past(req_stall))
   // A stalled result holds.
   `KEDC_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind keyed_edge_detect_cache kedc_checker u_kedc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
